/* sv/itoa_pkg.sv */
// Shared constants, types and state encodings for the decimal ASCII converter.
package itoa_pkg;

	// Width of the signed input word; bit VALUE_WIDTH-1 is the sign.
	localparam int VALUE_WIDTH = 32;

	// Decimal digits needed for any magnitude up to 2^(VALUE_WIDTH-1).
	localparam int DEC_DIGITS  = (VALUE_WIDTH * 3) / 10 + 1;
	localparam int BCD_W       = DEC_DIGITS * 4;
	localparam int IDX_W       = (DEC_DIGITS > 1) ? $clog2(DEC_DIGITS) : 1;
	localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] CHAR_ZERO  = 8'd48;
	localparam logic [7:0] CHAR_MINUS = 8'd45;

	// One converted number: sign plus packed BCD, digit 0 in the low nibble.
	typedef struct packed {
		logic             neg;
		logic [BCD_W-1:0] bcd;
	} conv_t;

	// Queue status seen by the front and back.
	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_CONV,
		F_DONE
	} front_state_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_SIGN,
		B_DIGIT
	} back_state_t;

endpackage

/* sv/itoa_front.sv */
// Front end: accepts a value, takes its magnitude and runs shift-add-3 BCD conversion.
module itoa_front import itoa_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          value_valid,
	output logic                          value_stall,
	input  logic signed [VALUE_WIDTH-1:0] value,
	input  queue_status_t                 qstat,
	output logic                          push,
	output conv_t                         push_data
);

	front_state_t            state_q, state_d;
	logic                    neg_q;
	logic [VALUE_WIDTH-1:0]  mag_q;
	logic [BCD_W-1:0]        bcd_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [VALUE_WIDTH-1:0]  raw;
	logic [VALUE_WIDTH-1:0]  mag_in;
	logic [BCD_W-1:0]        bcd_adj;
	logic                    accept;

	assign raw    = $unsigned(value);
	// Most negative value wraps to itself, which is the right unsigned magnitude.
	assign mag_in = raw[VALUE_WIDTH-1] ? (~raw + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : raw;
	assign accept = value_valid && !value_stall;

	always_comb begin
		bcd_adj = bcd_q;
		for (int i = 0; i < DEC_DIGITS; i++) begin
			if (bcd_q[i*4 +: 4] >= 4'd5) begin
				bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
			end
		end
	end

	always_comb begin
		state_d     = state_q;
		value_stall = 1'b1;
		push        = 1'b0;
		case (state_q)
			F_IDLE: begin
				value_stall = 1'b0;
				if (value_valid) begin
					state_d = F_CONV;
				end
			end
			F_CONV: begin
				if (cnt_q == {{(CNT_W-1){1'b0}}, 1'b1}) begin
					state_d = F_DONE;
				end
			end
			F_DONE: begin
				if (!qstat.full) begin
					push    = 1'b1;
					state_d = F_IDLE;
				end
			end
			default: begin
				state_d = F_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			neg_q <= raw[VALUE_WIDTH-1];
			mag_q <= mag_in;
			bcd_q <= '0;
			cnt_q <= CNT_W'(VALUE_WIDTH);
		end else if (state_q == F_CONV) begin
			bcd_q <= {bcd_adj[BCD_W-2:0], mag_q[VALUE_WIDTH-1]};
			mag_q <= {mag_q[VALUE_WIDTH-2:0], 1'b0};
			cnt_q <= cnt_q - {{(CNT_W-1){1'b0}}, 1'b1};
		end
	end

	assign push_data.neg = neg_q;
	assign push_data.bcd = bcd_q;

endmodule

/* sv/itoa_queue.sv */
// Small FIFO between the conversion front end and the character back end.
module itoa_queue import itoa_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  conv_t         push_data,
	input  logic          pop,
	output conv_t         pop_data,
	output queue_status_t qstat
);

	conv_t               mem [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                do_push;
	logic                do_pop;

	assign qstat.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign qstat.empty = (count_q == '0);
	assign do_push     = push && !qstat.full;
	assign do_pop      = pop && !qstat.empty;

	function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
		next_ptr = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + {{(QPTR_W-1){1'b0}}, 1'b1};
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	assign pop_data = mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + {{(QCNT_W-1){1'b0}}, 1'b1};
			end else if (do_pop && !do_push) begin
				count_q <= count_q - {{(QCNT_W-1){1'b0}}, 1'b1};
			end
		end
	end

endmodule

/* sv/itoa_back.sv */
// Back end: walks one converted number and emits its characters through an output register.
module itoa_back import itoa_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  queue_status_t qstat,
	input  conv_t         pop_data,
	output logic          pop,
	output logic          char_valid,
	input  logic          char_stall,
	output logic [7:0]    ascii_char,
	output logic          is_last
);

	back_state_t        state_q, state_d;
	logic [BCD_W-1:0]   bcd_q;
	logic [IDX_W-1:0]   idx_q;
	logic [IDX_W-1:0]   top_idx;
	logic [3:0]         cur_digit;
	logic               out_valid_q;
	logic [7:0]         char_q;
	logic               last_q;
	logic               adv;
	logic               emit;
	logic [7:0]         emit_char;
	logic               emit_last;

	// Highest nonzero digit; zero keeps index 0 so it prints as one '0'.
	always_comb begin
		top_idx = '0;
		for (int i = 1; i < DEC_DIGITS; i++) begin
			if (pop_data.bcd[i*4 +: 4] != 4'd0) begin
				top_idx = IDX_W'(i);
			end
		end
	end

	assign cur_digit = bcd_q[idx_q*4 +: 4];
	assign adv       = !out_valid_q || !char_stall;

	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		emit      = 1'b0;
		emit_char = CHAR_ZERO + {4'd0, cur_digit};
		emit_last = (idx_q == '0);
		case (state_q)
			B_IDLE: begin
				if (!qstat.empty) begin
					pop     = 1'b1;
					state_d = pop_data.neg ? B_SIGN : B_DIGIT;
				end
			end
			B_SIGN: begin
				emit      = 1'b1;
				emit_char = CHAR_MINUS;
				emit_last = 1'b0;
				if (adv) begin
					state_d = B_DIGIT;
				end
			end
			B_DIGIT: begin
				emit = 1'b1;
				if (adv && idx_q == '0) begin
					state_d = B_IDLE;
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (adv) begin
				out_valid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			bcd_q <= pop_data.bcd;
			idx_q <= top_idx;
		end else if (state_q == B_DIGIT && adv && idx_q != '0) begin
			idx_q <= idx_q - {{(IDX_W-1){1'b0}}, 1'b1};
		end
		if (adv && emit) begin
			char_q <= emit_char;
			last_q <= emit_last;
		end
	end

	assign char_valid = out_valid_q;
	assign ascii_char = char_q;
	assign is_last    = last_q;

endmodule

/* sv/signed_int_to_decimal_ascii_top.sv */
// Top level: signed integer to decimal ASCII text, front end, queue and back end.
//
//  channel | valid       | stall       | payload
//  --------+-------------+-------------+--------------------------
//  input   | value_valid | value_stall | value (signed)
//  output  | char_valid  | char_stall  | ascii_char, is_last
//
// The front end accepts a value and forms its magnitude, runs one step of the
// shift-add-3 loop per bit, then pushes into the queue. The back end pops a
// number and emits one character per cycle while char_stall is low, and
// overlaps the next conversion through a two-entry queue.
// arst_n clears the state machines, queue pointers and the output valid.
// A stalled output holds its register; the front keeps converting until the
// queue is full.
module signed_int_to_decimal_ascii_top import itoa_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          value_valid,
	output logic                          value_stall,
	input  logic signed [VALUE_WIDTH-1:0] value,
	output logic                          char_valid,
	input  logic                          char_stall,
	output logic [7:0]                    ascii_char,
	output logic                          is_last
);

	queue_status_t qstat;
	logic          push;
	logic          pop;
	conv_t         push_data;
	conv_t         pop_data;

	// Sign/magnitude and binary-to-BCD conversion.
	itoa_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.value_valid (value_valid),
		.value_stall (value_stall),
		.value       (value),
		.qstat       (qstat),
		.push        (push),
		.push_data   (push_data)
	);

	// Decouples conversion from character output.
	itoa_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.qstat     (qstat)
	);

	// Sign, leading-zero skip and digit emission.
	itoa_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.qstat      (qstat),
		.pop_data   (pop_data),
		.pop        (pop),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.ascii_char (ascii_char),
		.is_last    (is_last)
	);

endmodule
